// File: hw/rtl/mpmd_pkg.sv
// Shared types and constants for the multi-prefix message dispatcher.
package mpmd_pkg;

   localparam int NUM_HANDLERS_DEF   = 4;
   localparam int MAX_PREFIX_LEN_DEF = 8;
   localparam int MAX_CELLS          = 4;
   localparam int CSR_INDEX_W        = 3;
   localparam int CSR_DATA_W         = 64;
   localparam int HANDLER_W          = 2;
   localparam int COUNT_W            = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PREFIX_LENGTHS = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_HANDLER_COUNT = 3'd5;

   localparam logic [7:0] LOWER_A    = 8'd97;
   localparam logic [7:0] LOWER_Z    = 8'd122;
   localparam logic [7:0] CASE_DELTA = 8'd32;

   typedef enum logic [2:0] {
      EV_NO_MATCH  = 3'd0,
      EV_CONTINUES = 3'd1,
      EV_COMPLETE  = 3'd2,
      EV_BODY_BYTE = 3'd3,
      EV_BODY_END  = 3'd4,
      EV_IGNORED   = 3'd5
   } event_type;

   typedef enum logic {
      CMD_DATA   = 1'b0,
      CMD_BROKEN = 1'b1
   } command_type;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]           event_code;
      logic [HANDLER_W-1:0] handler_index;
      logic [7:0]           body_byte;
      logic                 body_valid;
   } rsp_payload_type;

   // Configuration writes steered to one cell.
   typedef struct packed {
      logic                  word_we;
      logic                  len_we;
      logic [CSR_DATA_W-1:0] wdata;
   } cell_cfg_type;

   // Per-request control broadcast to every cell.
   typedef struct packed {
      logic       first;
      logic       step;
      logic       clear;
      logic [7:0] folded;
   } cell_ctrl_type;

   typedef struct packed {
      logic hit;
      logic complete;
   } cell_status_type;

   function automatic logic [7:0] fold_upper(input logic [7:0] b);
      logic [7:0] r;
      r = b;
      if (b >= LOWER_A && b <= LOWER_Z) begin
         r = b - CASE_DELTA;
      end
      return r;
   endfunction

endpackage

// File: hw/rtl/mpmd_cell.sv
// One prefix-matching cell: holds a handler's prefix, length and candidate bit.
module mpmd_cell import mpmd_pkg::*; #(
   parameter int CELL_INDEX     = 0,
   parameter int MAX_PREFIX_LEN = MAX_PREFIX_LEN_DEF,
   localparam int POS_W         = $clog2(MAX_PREFIX_LEN),
   localparam int LEN_W         = $clog2(MAX_PREFIX_LEN + 1)
) (
   input  logic            clock,
   input  logic            reset,
   input  cell_cfg_type    cfg,
   input  cell_ctrl_type   ctrl,
   input  logic [POS_W-1:0] pos,
   input  logic            active,
   input  logic            done_in,
   output cell_status_type status,
   output logic            done_out
);

   logic [MAX_PREFIX_LEN-1:0][7:0] word_ff;
   logic [LEN_W-1:0]               len_ff;
   logic [LEN_W-1:0]               len_in;
   logic                           mask_ff;
   logic                           mask_in;
   logic [3:0]                     len_raw;
   logic                           live;
   logic                           match;
   logic                           last;

   // Lengths are clamped on write so the compare path sees a legal value.
   always_comb begin
      len_raw = cfg.wdata[4*CELL_INDEX +: 4];
      if (len_raw < 4'd2) begin
         len_in = LEN_W'(2);
      end else if (len_raw > 4'(MAX_PREFIX_LEN)) begin
         len_in = LEN_W'(MAX_PREFIX_LEN);
      end else begin
         len_in = LEN_W'(len_raw);
      end
   end

   always_comb begin
      live  = ctrl.step && active && mask_ff && !done_in;
      match = (LEN_W'(pos) < len_ff) && (word_ff[pos] == ctrl.folded);
      last  = (LEN_W'(pos) == len_ff - LEN_W'(1));
      status.complete = live && match && last;
      status.hit      = (ctrl.first && active && (word_ff[0] == ctrl.folded)) ||
                        (live && match);
      done_out = done_in || status.complete;
   end

   always_comb begin
      mask_in = mask_ff;
      if (ctrl.clear) begin
         mask_in = 1'b0;
      end else if (ctrl.first) begin
         mask_in = active && (word_ff[0] == ctrl.folded);
      end else if (live) begin
         mask_in = match;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff <= '0;
         len_ff  <= LEN_W'(2);
         mask_ff <= 1'b0;
      end else begin
         if (cfg.word_we) begin
            word_ff <= cfg.wdata[MAX_PREFIX_LEN*8-1:0];
         end
         if (cfg.len_we) begin
            len_ff <= len_in;
         end
         mask_ff <= mask_in;
      end
   end

endmodule

// File: hw/rtl/multi_prefix_message_dispatcher_unit.sv
// Top level of the multi-prefix message dispatcher: control, cell row and output buffer.
//
// Usage: bytes arrive on the req_ channel (valid/ready), each request holding a
// command bit and a data byte. Command 0 carries a received byte; command 1 is
// the handler reporting a broken body. Every request yields exactly one
// response on the rsp_ channel with an event code, the selected handler, and
// for body bytes the unfolded byte with body_valid set.
// Prefixes, their lengths and the handler count are written through the csr_
// port (index 0..3 prefix words, 4 packed lengths, 5 handler count) while no
// request is in flight.
// A response is registered at the edge that accepts its request, in the output
// register or, while that waits, the skid register. Throughput is one request
// per cycle until the skid register fills; all handler compares run in parallel
// across the cells, the priority pick rippling from cell 0 upward in the same cycle.
// A two-deep output buffer (output register plus skid register) lets a new
// request enter while a response waits; req_ready drops only when both hold
// data because the receiver has stalled.
// Reset is synchronous and clears the parser to idle, empties the output
// buffer, zeroes the prefix words and handler count and sets each length to two.
module multi_prefix_message_dispatcher_unit import mpmd_pkg::*; #(
   parameter int NUM_HANDLERS   = NUM_HANDLERS_DEF,
   parameter int MAX_PREFIX_LEN = MAX_PREFIX_LEN_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_payload_type        req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_payload_type        rsp_data,
   input  logic                   csr_write_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   localparam int NUM_CELLS = (NUM_HANDLERS < MAX_CELLS) ? NUM_HANDLERS : MAX_CELLS;
   localparam int POS_W     = $clog2(MAX_PREFIX_LEN);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_PREFIX = 3'b010,
      ST_BODY   = 3'b100
   } parse_state_type;

   parse_state_type        state_ff, state_in;
   logic [POS_W-1:0]       pos_ff, pos_in;
   logic [HANDLER_W-1:0]   sel_ff, sel_in;
   logic [COUNT_W-1:0]     count_ff;
   logic [COUNT_W-1:0]     count_eff;

   rsp_payload_type        out_ff, skid_ff, result;
   logic                   out_valid_ff, skid_valid_ff;

   logic                   accept;
   logic                   pop;
   cell_ctrl_type          ctrl;
   cell_cfg_type           cfg    [NUM_CELLS];
   cell_status_type        status [NUM_CELLS];
   logic [NUM_CELLS:0]     done;
   logic [NUM_CELLS-1:0]   active;
   logic [NUM_CELLS-1:0]   hit_vec;
   logic [NUM_CELLS-1:0]   complete_vec;
   logic [HANDLER_W-1:0]   enc;
   logic                   any_hit;
   logic                   any_complete;
   logic                   in_body;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign in_body   = (state_ff == ST_BODY);

   assign count_eff = (count_ff > COUNT_W'(NUM_CELLS)) ? COUNT_W'(NUM_CELLS) : count_ff;

   // Broadcast control; clear depends on the cells' hits but not the reverse.
   always_comb begin
      ctrl.folded = fold_upper(req_data.data_byte);
      ctrl.first  = accept && (req_data.command == CMD_DATA) &&
                    (state_ff != ST_PREFIX) && !in_body;
      ctrl.step   = accept && (req_data.command == CMD_DATA) && (state_ff == ST_PREFIX);
      ctrl.clear  = (accept && (req_data.command == CMD_BROKEN) && in_body) ||
                    ((ctrl.first || ctrl.step) && !any_hit);
   end

   assign done[0] = 1'b0;

   for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
      localparam logic [COUNT_W-1:0] CELL_ID = COUNT_W'(i);
      always_comb begin
         cfg[i].word_we = csr_write_en &&
                          (csr_index == CSR_PREFIX_WORD_0 + CSR_INDEX_W'(i));
         cfg[i].len_we  = csr_write_en && (csr_index == CSR_PREFIX_LENGTHS);
         cfg[i].wdata   = csr_wdata;
      end
      assign active[i]       = CELL_ID < count_eff;
      assign hit_vec[i]      = status[i].hit;
      assign complete_vec[i] = status[i].complete;

      mpmd_cell #(
         .CELL_INDEX     (i),
         .MAX_PREFIX_LEN (MAX_PREFIX_LEN)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cfg      (cfg[i]),
         .ctrl     (ctrl),
         .pos      (pos_ff),
         .active   (active[i]),
         .done_in  (done[i]),
         .status   (status[i]),
         .done_out (done[i+1])
      );
   end

   assign any_hit      = |hit_vec;
   assign any_complete = |complete_vec;

   // The ripple chain lets at most one cell complete, so a plain encoder works.
   always_comb begin
      enc = '0;
      for (int i = 0; i < NUM_CELLS; i++) begin
         if (complete_vec[i]) begin
            enc = HANDLER_W'(i);
         end
      end
   end

   always_comb begin
      state_in             = state_ff;
      pos_in               = pos_ff;
      sel_in               = sel_ff;
      result.event_code    = EV_IGNORED;
      result.handler_index = '0;
      result.body_byte     = '0;
      result.body_valid    = 1'b0;
      if (req_data.command == CMD_BROKEN) begin
         if (in_body) begin
            result.event_code    = EV_BODY_END;
            result.handler_index = sel_ff;
            state_in             = ST_IDLE;
            pos_in               = '0;
         end
      end else begin
         unique case (state_ff)
            ST_BODY: begin
               result.event_code    = EV_BODY_BYTE;
               result.handler_index = sel_ff;
               result.body_byte     = req_data.data_byte;
               result.body_valid    = 1'b1;
            end
            ST_PREFIX: begin
               if (any_complete) begin
                  result.event_code    = EV_COMPLETE;
                  result.handler_index = enc;
                  sel_in               = enc;
                  state_in             = ST_BODY;
                  pos_in               = '0;
               end else if (any_hit) begin
                  result.event_code = EV_CONTINUES;
                  pos_in            = pos_ff + POS_W'(1);
               end else begin
                  result.event_code = EV_NO_MATCH;
                  state_in          = ST_IDLE;
                  pos_in            = '0;
               end
            end
            default: begin
               if (any_hit) begin
                  result.event_code = EV_CONTINUES;
                  state_in          = ST_PREFIX;
                  pos_in            = POS_W'(1);
               end else begin
                  result.event_code = EV_NO_MATCH;
                  state_in          = ST_IDLE;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff   <= '0;
         sel_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
            pos_ff   <= pos_in;
            sel_ff   <= sel_in;
         end
         if (csr_write_en && (csr_index == CSR_HANDLER_COUNT)) begin
            count_ff <= csr_wdata[COUNT_W-1:0];
         end
      end
   end

   // Output register with a skid register behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_ff <= result;
         end else begin
            skid_ff <= result;
         end
      end
   end

`ifndef NO_ASSERTIONS
   a_single_winner: assert property (@(posedge clock) disable iff (reset)
      $onehot0(complete_vec))
      else $error("more than one cell completed on the same byte");

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register holds data while the output register is empty");

   a_idle_position: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (pos_ff == '0))
      else $error("match position nonzero while idle");

   a_body_flag: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.body_valid == (out_ff.event_code == EV_BODY_BYTE)))
      else $error("body_valid disagrees with the event code");

   a_complete_enters_body: assert property (@(posedge clock) disable iff (reset)
      (accept && ctrl.step && any_complete) |=> (state_ff == ST_BODY))
      else $error("completed prefix did not enter the body state");
`endif

endmodule

// File: verif/multi_prefix_message_dispatcher_unit_tb.sv
// Self-checking testbench for the multi-prefix message dispatcher with a built-in prefix predictor.
module multi_prefix_message_dispatcher_unit_tb import mpmd_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned HOLD_AT     = 120;
   localparam int unsigned HOLD_CYCLES = 80;
   localparam int unsigned IDLE_PCT    = 21;
   localparam logic [7:0]  UPPER_A     = 8'h41;

   typedef enum logic [1:0] {
      PS_IDLE   = 2'd0,
      PS_PREFIX = 2'd1,
      PS_BODY   = 2'd2
   } parse_phase_type;

   logic                   clock        = 1'b0;
   logic                   reset        = 1'b1;
   logic                   req_valid    = 1'b0;
   logic                   req_ready;
   req_payload_type        req_data     = '0;
   logic                   rsp_valid;
   logic                   rsp_ready    = 1'b0;
   rsp_payload_type        rsp_data;
   logic                   csr_write_en = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index    = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata    = '0;

   // Shadow copy of the configuration registers.
   logic [63:0] prefix_words [4] = '{default: '0};
   logic [15:0] prefix_lens  = '0;
   logic [2:0]  handler_cnt  = '0;

   // Predicted parser state.
   parse_phase_type parse_phase  = PS_IDLE;
   logic [3:0]      live_mask    = '0;
   logic [3:0]      match_pos    = '0;
   logic [1:0]      chosen_hdlr  = '0;

   req_payload_type pending_reqs [$];
   rsp_payload_type expected_rsps [$];
   rsp_payload_type want_rsp;

   bit          calm          = 1'b0;
   bit          hold_started  = 1'b0;
   int unsigned hold_left     = 0;
   int unsigned queued_total  = 0;
   int unsigned accepted_total = 0;
   int unsigned checked_total = 0;
   int unsigned mismatches    = 0;
   int unsigned config_sets   = 0;
   int unsigned cycle_count   = 0;
   int unsigned event_tally [6] = '{default: 0};

   multi_prefix_message_dispatcher_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic logic [7:0] to_upper(input logic [7:0] b);
      return (b >= LOWER_A && b <= LOWER_Z) ? b - CASE_DELTA : b;
   endfunction

   function automatic int unsigned active_count();
      int unsigned n;
      n = 32'(handler_cnt);
      if (n > NUM_HANDLERS_DEF) n = NUM_HANDLERS_DEF;
      if (n > 4) n = 4;
      return n;
   endfunction

   function automatic int unsigned eff_len(input int unsigned h);
      int unsigned l;
      l = 32'(prefix_lens[(h % 4) * 4 +: 4]);
      if (l < 2) l = 2;
      if (l > MAX_PREFIX_LEN_DEF) l = MAX_PREFIX_LEN_DEF;
      return l;
   endfunction

   function automatic logic [7:0] word_char(input int unsigned h, input int unsigned pos);
      return prefix_words[h % 4][(pos % 8) * 8 +: 8];
   endfunction

   // Advances the predicted parser by one request and returns the response it must produce.
   function automatic rsp_payload_type dispatch_step(input req_payload_type rq);
      rsp_payload_type r;
      logic [7:0]      ch;
      int unsigned     n, len, pos, i;
      bit              done;
      r = '0;
      r.event_code = EV_IGNORED;
      n = active_count();
      ch = to_upper(rq.data_byte);
      done = 1'b0;
      if (rq.command == CMD_BROKEN) begin
         if (parse_phase == PS_BODY) begin
            r.event_code    = EV_BODY_END;
            r.handler_index = chosen_hdlr;
            parse_phase     = PS_IDLE;
            live_mask       = '0;
            match_pos       = '0;
         end
      end else if (parse_phase == PS_BODY) begin
         r.event_code    = EV_BODY_BYTE;
         r.handler_index = chosen_hdlr;
         r.body_byte     = rq.data_byte;
         r.body_valid    = 1'b1;
      end else if (parse_phase == PS_PREFIX) begin
         pos = 32'(match_pos);
         r.event_code = EV_NO_MATCH;
         // The first handler to complete wins; handlers above it are not visited.
         for (i = 0; i < n && !done; i++) begin
            if (live_mask[i]) begin
               len = eff_len(i);
               if (pos < len && word_char(i, pos) == ch) begin
                  r.event_code = EV_CONTINUES;
                  if (pos == len - 1) begin
                     r.event_code = EV_COMPLETE;
                     chosen_hdlr  = i[1:0];
                     done         = 1'b1;
                  end
               end else begin
                  live_mask[i] = 1'b0;
               end
            end
         end
         if (r.event_code == EV_NO_MATCH) begin
            parse_phase = PS_IDLE;
            live_mask   = '0;
            match_pos   = '0;
         end else if (r.event_code == EV_COMPLETE) begin
            r.handler_index = chosen_hdlr;
            parse_phase     = PS_BODY;
            match_pos       = '0;
         end else begin
            match_pos = match_pos + 4'd1;
         end
      end else begin
         parse_phase  = PS_IDLE;
         live_mask    = '0;
         r.event_code = EV_NO_MATCH;
         for (i = 0; i < n; i++) begin
            if (word_char(i, 0) == ch) begin
               live_mask[i] = 1'b1;
               r.event_code = EV_CONTINUES;
            end
         end
         if (r.event_code == EV_CONTINUES) begin
            parse_phase = PS_PREFIX;
            match_pos   = 4'd1;
         end
      end
      return r;
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            expected_rsps.push_back(dispatch_step(req_data));
            accepted_total++;
         end
         if (!req_valid || req_ready) begin
            if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               req_valid <= 1'b1;
               req_data  <= pending_reqs.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor and receiver stalls.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (rsp_data.event_code <= EV_IGNORED) event_tally[rsp_data.event_code]++;
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding: event_code %0d",
                      rsp_data.event_code);
               mismatches++;
            end else begin
               want_rsp = expected_rsps.pop_front();
               if (rsp_data.event_code !== want_rsp.event_code) begin
                  $error("event_code: expected %0d, actual %0d",
                         want_rsp.event_code, rsp_data.event_code);
                  mismatches++;
               end
               if (rsp_data.handler_index !== want_rsp.handler_index) begin
                  $error("handler_index: expected %0d, actual %0d",
                         want_rsp.handler_index, rsp_data.handler_index);
                  mismatches++;
               end
               if (rsp_data.body_byte !== want_rsp.body_byte) begin
                  $error("body_byte: expected 0x%02h, actual 0x%02h",
                         want_rsp.body_byte, rsp_data.body_byte);
                  mismatches++;
               end
               if (rsp_data.body_valid !== want_rsp.body_valid) begin
                  $error("body_valid: expected %0d, actual %0d",
                         want_rsp.body_valid, rsp_data.body_valid);
                  mismatches++;
               end
            end
            checked_total++;
         end
         // One long stall so that the output buffer fills and the request side backs up.
         if (!hold_started && checked_total >= HOLD_AT) begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic queue_req(input command_type c, input logic [7:0] b);
      req_payload_type rq;
      rq.command   = c;
      rq.data_byte = b;
      pending_reqs.push_back(rq);
      queued_total++;
   endtask

   task automatic await_idle();
      do @(negedge clock);
      while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx < CSR_PREFIX_LENGTHS) begin
         prefix_words[idx[1:0]] = val;
      end else if (idx == CSR_PREFIX_LENGTHS) begin
         prefix_lens = val[15:0];
      end else if (idx == CSR_HANDLER_COUNT) begin
         handler_cnt = val[2:0];
         config_sets++;
      end
   endtask

   // Sends the first cnt characters of a handler's prefix, letters in random case.
   task automatic send_prefix(input int unsigned h, input int unsigned cnt);
      int unsigned k;
      logic [7:0]  ch;
      for (k = 0; k < cnt; k++) begin
         ch = word_char(h, k);
         if (ch >= UPPER_A && ch <= LOWER_Z - CASE_DELTA && $urandom_range(0, 1))
            ch = ch + CASE_DELTA;
         queue_req(CMD_DATA, ch);
      end
   endtask

   task automatic random_config();
      logic [63:0] w;
      logic [15:0] l;
      int unsigned h, k;
      for (h = 0; h < 4; h++) begin
         // A small alphabet makes prefixes overlap often.
         for (k = 0; k < 8; k++)
            w[k * 8 +: 8] = ($urandom_range(0, 3) != 0) ?
                            8'(UPPER_A + $urandom_range(0, 3)) :
                            8'($urandom_range(0, 255));
         write_reg(CSR_PREFIX_WORD_0 + CSR_INDEX_W'(h), w);
         l[h * 4 +: 4] = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(2, 5))
                                                     : 4'($urandom_range(0, 15));
      end
      write_reg(CSR_PREFIX_LENGTHS, {48'd0, l});
      write_reg(CSR_HANDLER_COUNT,
                ($urandom_range(0, 9) < 6) ? 64'd4 : 64'($urandom_range(0, 7)));
   endtask

   task automatic random_phase(input int unsigned quota);
      int unsigned start, h, r;
      start = queued_total;
      while (queued_total - start < quota) begin
         r = $urandom_range(0, 99);
         h = $urandom_range(0, 3);
         if (r < 65) begin
            send_prefix(h, eff_len(h));
            repeat ($urandom_range(0, 5)) queue_req(CMD_DATA, 8'($urandom));
            if ($urandom_range(0, 9) != 0) queue_req(CMD_BROKEN, 8'($urandom));
         end else if (r < 80) begin
            send_prefix(h, $urandom_range(1, eff_len(h) - 1));
            queue_req(CMD_DATA, 8'($urandom));
         end else begin
            queue_req($urandom_range(0, 1) ? CMD_BROKEN : CMD_DATA, 8'($urandom));
         end
      end
      await_idle();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Nothing registered yet: every byte misses and a broken-body report is ignored.
      @(negedge clock);
      queue_req(CMD_DATA, 8'h41);
      queue_req(CMD_BROKEN, 8'h00);
      await_idle();

      // Handlers 1 and 2 share the two-character prefix, handler 0 extends it,
      // handler 3 has a zero length field, and the count is above the limit.
      write_reg(CSR_PREFIX_WORD_0 + CSR_INDEX_W'(0), 64'h0000_0000_5958_5441);
      write_reg(CSR_PREFIX_WORD_0 + CSR_INDEX_W'(1), 64'h0000_0000_0000_5441);
      write_reg(CSR_PREFIX_WORD_0 + CSR_INDEX_W'(2), 64'hFFFF_FFFF_FFFF_5441);
      write_reg(CSR_PREFIX_WORD_0 + CSR_INDEX_W'(3), 64'h0000_0000_0000_5142);
      write_reg(CSR_PREFIX_LENGTHS, 64'h0224);
      write_reg(CSR_HANDLER_COUNT, 64'd7);
      @(negedge clock);
      queue_req(CMD_DATA, 8'h61);     // lower-case first character
      queue_req(CMD_BROKEN, 8'h00);   // broken body while reading the prefix
      queue_req(CMD_DATA, 8'h74);     // handlers 1 and 2 both match their last character; handler 1 wins
      queue_req(CMD_DATA, 8'h00);
      queue_req(CMD_DATA, 8'hFF);
      queue_req(CMD_DATA, 8'h7A);     // body bytes are not folded
      queue_req(CMD_BROKEN, 8'h00);
      queue_req(CMD_BROKEN, 8'h00);   // broken body while idle
      queue_req(CMD_DATA, 8'h62);
      queue_req(CMD_DATA, 8'h7B);     // no candidate survives
      queue_req(CMD_DATA, 8'h42);
      queue_req(CMD_DATA, 8'h71);
      queue_req(CMD_BROKEN, 8'hFF);
      queue_req(CMD_DATA, 8'h60);
      await_idle();

      // Longest prefix of all-ones characters, length field above the maximum.
      write_reg(CSR_PREFIX_WORD_0 + CSR_INDEX_W'(0), 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(CSR_PREFIX_LENGTHS, 64'hFFFF);
      write_reg(CSR_HANDLER_COUNT, 64'd1);
      @(negedge clock);
      repeat (8) queue_req(CMD_DATA, 8'hFF);
      queue_req(CMD_BROKEN, 8'h00);
      await_idle();

      random_config();
      @(negedge clock);
      random_phase(135);
      random_config();
      @(negedge clock);
      random_phase(135);
      random_config();
      calm = 1'b1;
      @(negedge clock);
      random_phase(135);
      calm = 1'b0;
      random_config();
      @(negedge clock);
      random_phase(135);

      repeat (20) @(posedge clock);
      $display("Ran %0d requests and checked %0d responses over %0d register settings.",
               accepted_total, checked_total, config_sets);
      $display("Events seen: miss %0d, continue %0d, complete %0d, body %0d, end %0d, ignored %0d",
               event_tally[0], event_tally[1], event_tally[2], event_tally[3],
               event_tally[4], event_tally[5]);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/mpmd_pkg.sv
hw/rtl/mpmd_cell.sv
hw/rtl/multi_prefix_message_dispatcher_unit.sv
verif/multi_prefix_message_dispatcher_unit_tb.sv
